>>> src/stb_pkg.sv
// Shared constants and types for the software timer bank.
package stb_pkg;

    localparam int NUM_TIMERS = 8;
    localparam int IDX_W      = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
    localparam int FUNC_W     = 3;
    localparam int ID_W       = 8;
    localparam int CNT_W      = 32;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK       = 3'd0,
        FUNC_START_ONCE = 3'd1,
        FUNC_START_AUTO = 3'd2,
        FUNC_STOP       = 3'd3,
        FUNC_CHECK      = 3'd4
    } t_func;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SWEEP,
        ST_EXEC,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic             cnt_we;
        logic [CNT_W-1:0] cnt_wdata;
        logic             rel_we;
        logic             flag_we;
        logic             flag_wdata;
        logic             mode_we;
        logic             mode_wdata;
        logic             fired_set;
        logic             out_load;
        logic             idx_inc;
    } t_ctrl;

endpackage

>>> src/soft_timer_bank_unit.sv
// Top level of the software timer bank with its sequencer and shared decrement unit.
// A tick word sweeps the bank one timer per cycle, then passes through the done state to the result.
// Start, stop, check and unused words pass through the execute state and then the done state.
// The input is stalled while a word is in work and while a finished result waits for room.
// Synchronous active-low reset clears all counts, reloads, flags and modes to zero.
module soft_timer_bank_unit (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [stb_pkg::FUNC_W-1:0] i_func,
    input  logic [stb_pkg::ID_W-1:0]   i_timer_id,
    input  logic [stb_pkg::CNT_W-1:0]  i_period,
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_fired
);

    stb_pkg::t_state r_state, n_state;
    logic [stb_pkg::FUNC_W-1:0]   r_func;
    logic [stb_pkg::ID_W-1:0]     r_id;
    logic [stb_pkg::CNT_W-1:0]    r_period;
    logic [stb_pkg::IDX_W-1:0]    r_idx;
    logic                         r_fired_pend;
    logic                         r_out_valid;
    logic                         r_fired;

    logic [stb_pkg::CNT_W-1:0] r_countdown [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::CNT_W-1:0] r_reload    [stb_pkg::NUM_TIMERS];
    logic [stb_pkg::NUM_TIMERS-1:0] r_flag;
    logic [stb_pkg::NUM_TIMERS-1:0] r_mode;

    logic                      w_accept;
    logic                      w_last;
    logic                      w_id_ok;
    logic                      w_out_free;
    logic [stb_pkg::IDX_W-1:0] w_sel;
    logic [stb_pkg::CNT_W-1:0] w_cur;
    logic [stb_pkg::CNT_W-1:0] w_dec;
    logic                      w_dec_zero;
    stb_pkg::t_ctrl            w_ctrl;

    assign o_in_stall  = (r_state != stb_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && !o_in_stall;
    assign w_last      = (r_idx == stb_pkg::IDX_W'(stb_pkg::NUM_TIMERS - 1));
    assign w_id_ok     = (r_id < stb_pkg::ID_W'(stb_pkg::NUM_TIMERS));
    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign w_sel       = (r_state == stb_pkg::ST_SWEEP) ? r_idx : r_id[stb_pkg::IDX_W-1:0];
    assign w_cur       = r_countdown[w_sel];
    assign w_dec       = w_cur - stb_pkg::CNT_W'(1);
    assign w_dec_zero  = (w_dec == '0);
    assign o_out_valid = r_out_valid;
    assign o_fired     = r_fired;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            stb_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = (stb_pkg::t_func'(i_func) == stb_pkg::FUNC_TICK) ?
                              stb_pkg::ST_SWEEP : stb_pkg::ST_EXEC;
                end
            end
            stb_pkg::ST_SWEEP: begin
                if (w_last) begin
                    n_state = stb_pkg::ST_DONE;
                end
            end
            stb_pkg::ST_EXEC: begin
                n_state = stb_pkg::ST_DONE;
            end
            stb_pkg::ST_DONE: begin
                if (w_out_free) begin
                    n_state = stb_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = stb_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        w_ctrl = '0;
        unique case (r_state)
            stb_pkg::ST_SWEEP: begin
                w_ctrl.idx_inc = 1'b1;
                if (w_cur != '0) begin
                    w_ctrl.cnt_we    = 1'b1;
                    w_ctrl.cnt_wdata = w_dec;
                    if (w_dec_zero) begin
                        w_ctrl.flag_we    = 1'b1;
                        w_ctrl.flag_wdata = 1'b1;
                        if (r_mode[w_sel]) begin
                            w_ctrl.cnt_wdata = r_reload[w_sel];
                        end
                    end
                end
            end
            stb_pkg::ST_EXEC: begin
                if (w_id_ok) begin
                    unique case (r_func)
                        stb_pkg::FUNC_START_ONCE, stb_pkg::FUNC_START_AUTO: begin
                            w_ctrl.cnt_we     = 1'b1;
                            w_ctrl.cnt_wdata  = r_period;
                            w_ctrl.rel_we     = 1'b1;
                            w_ctrl.flag_we    = 1'b1;
                            w_ctrl.mode_we    = 1'b1;
                            w_ctrl.mode_wdata = (r_func == stb_pkg::FUNC_START_AUTO);
                        end
                        stb_pkg::FUNC_STOP: begin
                            w_ctrl.cnt_we  = 1'b1;
                            w_ctrl.flag_we = 1'b1;
                            w_ctrl.mode_we = 1'b1;
                        end
                        stb_pkg::FUNC_CHECK: begin
                            if (r_flag[w_sel]) begin
                                w_ctrl.flag_we   = 1'b1;
                                w_ctrl.fired_set = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            stb_pkg::ST_DONE: begin
                w_ctrl.out_load = w_out_free;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= stb_pkg::ST_IDLE;
            r_idx        <= '0;
            r_fired_pend <= 1'b0;
            r_out_valid  <= 1'b0;
            r_fired      <= 1'b0;
            r_flag       <= '0;
            r_mode       <= '0;
            for (int k = 0; k < stb_pkg::NUM_TIMERS; k++) begin
                r_countdown[k] <= '0;
                r_reload[k]    <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_accept) begin
                r_func       <= i_func;
                r_id         <= i_timer_id;
                r_period     <= i_period;
                r_idx        <= '0;
                r_fired_pend <= 1'b0;
            end else if (w_ctrl.idx_inc) begin
                r_idx <= r_idx + stb_pkg::IDX_W'(1);
            end
            if (w_ctrl.fired_set) begin
                r_fired_pend <= 1'b1;
            end
            if (w_ctrl.cnt_we) begin
                r_countdown[w_sel] <= w_ctrl.cnt_wdata;
            end
            if (w_ctrl.rel_we) begin
                r_reload[w_sel] <= r_period;
            end
            if (w_ctrl.flag_we) begin
                r_flag[w_sel] <= w_ctrl.flag_wdata;
            end
            if (w_ctrl.mode_we) begin
                r_mode[w_sel] <= w_ctrl.mode_wdata;
            end
            if (w_ctrl.out_load) begin
                r_out_valid <= 1'b1;
                r_fired     <= r_fired_pend;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

endmodule

>>> src/stb_checker.sv
// Port-level checker for the software timer bank and its bind statement.
module stb_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       i_in_valid,
    input logic                       o_in_stall,
    input logic                       o_out_valid,
    input logic                       i_out_stall,
    input logic                       o_fired
);

    logic w_in_acc;

    assign w_in_acc = i_in_valid && !o_in_stall;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("Result word dropped while stalled.");

    a_fired_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> $stable(o_fired))
        else $error("Result word changed while stalled.");

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> o_in_stall ##1 o_in_stall)
        else $error("Input taken again before the word was finished.");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("Reset did not empty the block.");

    a_no_early_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc && !o_out_valid |=> !o_out_valid)
        else $error("Result word appeared one cycle after accept.");

endmodule

bind soft_timer_bank_unit stb_checker u_stb_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_fired     (o_fired)
);
